@@ hdl/m3inv_pkg.sv @@
package m3inv_pkg;

   localparam int DEF_FRAC_BITS = 16;
   localparam int DEF_WORD_BITS = 32;
   localparam int NUM_ELEMS = 9;

   // operand positions (row-major element numbers) of the two products of each cofactor
   localparam int unsigned COF_IDX [0:NUM_ELEMS-1][0:3] = '{
      '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
      '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
   };

   typedef struct packed {
      logic singular;
      logic saturated;
   } rsp_flags_type;

endpackage

@@ hdl/m3inv_req_if.sv @@
interface m3inv_req_if #(parameter int WORD_BITS = 32);
   logic valid;
   logic ready;
   logic signed [WORD_BITS-1:0] m_r0c0;
   logic signed [WORD_BITS-1:0] m_r0c1;
   logic signed [WORD_BITS-1:0] m_r0c2;
   logic signed [WORD_BITS-1:0] m_r1c0;
   logic signed [WORD_BITS-1:0] m_r1c1;
   logic signed [WORD_BITS-1:0] m_r1c2;
   logic signed [WORD_BITS-1:0] m_r2c0;
   logic signed [WORD_BITS-1:0] m_r2c1;
   logic signed [WORD_BITS-1:0] m_r2c2;

   modport source (output valid, input ready, output m_r0c0, m_r0c1, m_r0c2,
                   m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2);
   modport sink (input valid, output ready, input m_r0c0, m_r0c1, m_r0c2,
                 m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2);
endinterface

@@ hdl/m3inv_rsp_if.sv @@
interface m3inv_rsp_if #(parameter int WORD_BITS = 32);
   logic valid;
   logic ready;
   logic signed [WORD_BITS-1:0] inv_r0c0;
   logic signed [WORD_BITS-1:0] inv_r0c1;
   logic signed [WORD_BITS-1:0] inv_r0c2;
   logic signed [WORD_BITS-1:0] inv_r1c0;
   logic signed [WORD_BITS-1:0] inv_r1c1;
   logic signed [WORD_BITS-1:0] inv_r1c2;
   logic signed [WORD_BITS-1:0] inv_r2c0;
   logic signed [WORD_BITS-1:0] inv_r2c1;
   logic signed [WORD_BITS-1:0] inv_r2c2;
   logic singular;
   logic saturated;

   modport source (output valid, input ready, output inv_r0c0, inv_r0c1, inv_r0c2,
                   inv_r1c0, inv_r1c1, inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2,
                   singular, saturated);
   modport sink (input valid, output ready, input inv_r0c0, inv_r0c1, inv_r0c2,
                 inv_r1c0, inv_r1c1, inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2,
                 singular, saturated);
endinterface

@@ hdl/m3inv_lane.sv @@
module m3inv_lane #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic clock,
   input  logic en,
   input  logic signed [WORD_BITS-1:0] a,
   input  logic signed [WORD_BITS-1:0] b,
   input  logic signed [WORD_BITS-1:0] c,
   input  logic signed [WORD_BITS-1:0] d,
   input  logic det_neg,
   input  logic [3*WORD_BITS+2:0] ad [0:WORD_BITS],
   input  logic singular,
   output logic signed [2*WORD_BITS:0] cof,
   output logic [WORD_BITS-1:0] result,
   output logic sat
);
   localparam int PW = 2 * WORD_BITS;
   localparam int CW = 2 * WORD_BITS + 1;
   localparam int DW = 3 * WORD_BITS + 3;
   localparam int RW = DW + WORD_BITS + 1;
   localparam int QW = WORD_BITS + 1;
   localparam int NSTEP = WORD_BITS + 1;

   logic signed [PW-1:0] p1_ff, p2_ff;
   logic signed [CW-1:0] cof_ff;
   logic signed [CW-1:0] cofd_ff [0:1];
   logic [CW-1:0] cof_mag;
   logic [RW-1:0] rem_ff [0:NSTEP];
   logic [QW-1:0] q_ff [0:NSTEP];
   logic negq_ff [0:NSTEP];
   logic czero_ff [0:NSTEP];
   logic cneg_ff [0:NSTEP];
   logic [WORD_BITS-1:0] max_val, min_val, q_low;
   logic big;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= PW'(a) * PW'(b);
         p2_ff <= PW'(c) * PW'(d);
         cof_ff <= CW'(p1_ff) - CW'(p2_ff);
         cofd_ff[0] <= cof_ff;
         cofd_ff[1] <= cofd_ff[0];
      end
   end

   assign cof = cof_ff;

   assign cof_mag = cofd_ff[1][CW-1] ? CW'(-cofd_ff[1]) : CW'(cofd_ff[1]);

   // numerator magnitude is the cofactor scaled by two fraction widths
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(cof_mag) << (2 * FRAC_BITS);
         q_ff[0] <= '0;
         negq_ff[0] <= cofd_ff[1][CW-1] ^ det_neg;
         czero_ff[0] <= (cofd_ff[1] == '0);
         cneg_ff[0] <= cofd_ff[1][CW-1];
      end
   end

   // one restoring step per quotient bit, most significant first
   for (genvar j = 0; j < NSTEP; j++) begin : g_step
      logic [RW-1:0] dv;
      logic ge;
      assign dv = RW'(ad[j]) << (WORD_BITS - j);
      assign ge = (rem_ff[j] >= dv);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= ge ? (rem_ff[j] - dv) : rem_ff[j];
            q_ff[j+1] <= q_ff[j] | (QW'(ge) << (WORD_BITS - j));
            negq_ff[j+1] <= negq_ff[j];
            czero_ff[j+1] <= czero_ff[j];
            cneg_ff[j+1] <= cneg_ff[j];
         end
      end
   end

   assign max_val = {1'b0, {(WORD_BITS-1){1'b1}}};
   assign min_val = {1'b1, {(WORD_BITS-1){1'b0}}};
   assign q_low = q_ff[NSTEP][WORD_BITS-1:0];

   // a negative quotient may reach exactly the signed minimum
   assign big = negq_ff[NSTEP]
              ? (q_ff[NSTEP][WORD_BITS] | (q_ff[NSTEP][WORD_BITS-1] &
                 (|q_ff[NSTEP][WORD_BITS-2:0])))
              : (q_ff[NSTEP][WORD_BITS] | q_ff[NSTEP][WORD_BITS-1]);

   always_comb begin
      if (singular) begin
         sat = !czero_ff[NSTEP];
         result = czero_ff[NSTEP] ? '0 : (cneg_ff[NSTEP] ? min_val : max_val);
      end else if (big) begin
         sat = 1'b1;
         result = negq_ff[NSTEP] ? min_val : max_val;
      end else begin
         sat = 1'b0;
         result = negq_ff[NSTEP] ? WORD_BITS'(-q_low) : q_low;
      end
   end
endmodule

@@ hdl/m3inv_det.sv @@
module m3inv_det #(
   parameter int WORD_BITS = 32
) (
   input  logic clock,
   input  logic en,
   input  logic signed [WORD_BITS-1:0] m0,
   input  logic signed [WORD_BITS-1:0] m1,
   input  logic signed [WORD_BITS-1:0] m2,
   input  logic signed [2*WORD_BITS:0] cof0,
   input  logic signed [2*WORD_BITS:0] cof3,
   input  logic signed [2*WORD_BITS:0] cof6,
   output logic det_neg,
   output logic [3*WORD_BITS+2:0] ad [0:WORD_BITS],
   output logic singular
);
   localparam int PL = 2 * WORD_BITS + 1;
   localparam int DW = 3 * WORD_BITS + 3;
   localparam int HW = WORD_BITS + 1;
   localparam int NSTEP = WORD_BITS + 1;

   logic signed [WORD_BITS-1:0] m_ff [0:1][0:2];
   logic signed [2*WORD_BITS:0] cofs [0:2];
   logic signed [PL-1:0] ph_ff [0:2];
   logic signed [PL-1:0] pl_ff [0:2];
   logic signed [DW-1:0] det_ff;
   logic [DW-1:0] ad_ff [0:WORD_BITS];
   logic sing_ff [0:NSTEP];

   assign cofs[0] = cof0;
   assign cofs[1] = cof3;
   assign cofs[2] = cof6;

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0][0] <= m0;
         m_ff[0][1] <= m1;
         m_ff[0][2] <= m2;
         m_ff[1] <= m_ff[0];
      end
   end

   // each cofactor is split into a signed high word and an unsigned low word
   for (genvar i = 0; i < 3; i++) begin : g_part
      logic signed [HW-1:0] hi;
      logic signed [HW-1:0] lo;
      assign hi = cofs[i][2*WORD_BITS:WORD_BITS];
      assign lo = $signed({1'b0, cofs[i][WORD_BITS-1:0]});
      always_ff @(posedge clock) begin
         if (en) begin
            ph_ff[i] <= PL'(m_ff[1][i]) * PL'(hi);
            pl_ff[i] <= PL'(m_ff[1][i]) * PL'(lo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= (DW'(ph_ff[0]) <<< WORD_BITS) + DW'(pl_ff[0])
                 + (DW'(ph_ff[1]) <<< WORD_BITS) + DW'(pl_ff[1])
                 + (DW'(ph_ff[2]) <<< WORD_BITS) + DW'(pl_ff[2]);
         ad_ff[0] <= det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
         sing_ff[0] <= (det_ff == '0);
         for (int j = 1; j <= WORD_BITS; j++) begin
            ad_ff[j] <= ad_ff[j-1];
         end
         for (int j = 1; j <= NSTEP; j++) begin
            sing_ff[j] <= sing_ff[j-1];
         end
      end
   end

   assign det_neg = det_ff[DW-1];
   assign ad = ad_ff;
   assign singular = sing_ff[NSTEP];
endmodule

@@ hdl/m3inv_merge.sv @@
module m3inv_merge #(
   parameter int WORD_BITS = 32
) (
   input  logic clock,
   input  logic en,
   input  logic [WORD_BITS-1:0] result [0:8],
   input  logic [8:0] sat,
   input  logic singular,
   output logic [WORD_BITS-1:0] inv [0:8],
   output m3inv_pkg::rsp_flags_type flags
);
   import m3inv_pkg::*;

   logic [WORD_BITS-1:0] inv_ff [0:NUM_ELEMS-1];
   rsp_flags_type flags_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         inv_ff <= result;
         flags_ff.singular <= singular;
         flags_ff.saturated <= |sat;
      end
   end

   assign inv = inv_ff;
   assign flags = flags_ff;
endmodule

@@ hdl/matrix3x3_inverse_unit.sv @@
// 3x3 matrix inverse by the adjugate in signed fixed point. One matrix is taken per clock
// unless the output stalls, and its inverse comes out of the merge register. Nine lanes form
// one cofactor each and divide it by the shared determinant in a restoring divider with one
// pipeline stage per quotient bit, WORD_BITS+1 stages. The whole pipeline holds while a
// finished result is not taken. A zero determinant raises singular and every element with a
// nonzero cofactor goes to full scale with that cofactor's sign.
module matrix3x3_inverse_unit #(
   parameter int FRAC_BITS = m3inv_pkg::DEF_FRAC_BITS,
   parameter int WORD_BITS = m3inv_pkg::DEF_WORD_BITS
) (
   input logic clock,
   input logic reset,
   m3inv_req_if.sink req,
   m3inv_rsp_if.source rsp
);
   import m3inv_pkg::*;

   localparam int NS = WORD_BITS + 7;

   logic [NS-1:0] valid_ff;
   logic adv;
   logic signed [WORD_BITS-1:0] m [0:NUM_ELEMS-1];
   logic signed [2*WORD_BITS:0] cof [0:NUM_ELEMS-1];
   logic [WORD_BITS-1:0] result [0:NUM_ELEMS-1];
   logic [WORD_BITS-1:0] inv [0:NUM_ELEMS-1];
   logic [NUM_ELEMS-1:0] sat;
   logic [3*WORD_BITS+2:0] ad [0:WORD_BITS];
   logic det_neg, singular;
   rsp_flags_type flags;

   assign adv = !valid_ff[NS-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NS-2:0], req.valid};
      end
   end

   assign m[0] = req.m_r0c0;
   assign m[1] = req.m_r0c1;
   assign m[2] = req.m_r0c2;
   assign m[3] = req.m_r1c0;
   assign m[4] = req.m_r1c1;
   assign m[5] = req.m_r1c2;
   assign m[6] = req.m_r2c0;
   assign m[7] = req.m_r2c1;
   assign m[8] = req.m_r2c2;

   for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_lane
      m3inv_lane #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_lane (
         .clock    (clock),
         .en       (adv),
         .a        (m[COF_IDX[k][0]]),
         .b        (m[COF_IDX[k][1]]),
         .c        (m[COF_IDX[k][2]]),
         .d        (m[COF_IDX[k][3]]),
         .det_neg  (det_neg),
         .ad       (ad),
         .singular (singular),
         .cof      (cof[k]),
         .result   (result[k]),
         .sat      (sat[k])
      );
   end

   m3inv_det #(.WORD_BITS(WORD_BITS)) u_det (
      .clock    (clock),
      .en       (adv),
      .m0       (m[0]),
      .m1       (m[1]),
      .m2       (m[2]),
      .cof0     (cof[0]),
      .cof3     (cof[3]),
      .cof6     (cof[6]),
      .det_neg  (det_neg),
      .ad       (ad),
      .singular (singular)
   );

   m3inv_merge #(.WORD_BITS(WORD_BITS)) u_merge (
      .clock    (clock),
      .en       (adv),
      .result   (result),
      .sat      (sat),
      .singular (singular),
      .inv      (inv),
      .flags    (flags)
   );

   assign rsp.valid = valid_ff[NS-1];
   assign rsp.inv_r0c0 = inv[0];
   assign rsp.inv_r0c1 = inv[1];
   assign rsp.inv_r0c2 = inv[2];
   assign rsp.inv_r1c0 = inv[3];
   assign rsp.inv_r1c1 = inv[4];
   assign rsp.inv_r1c2 = inv[5];
   assign rsp.inv_r2c0 = inv[6];
   assign rsp.inv_r2c1 = inv[7];
   assign rsp.inv_r2c2 = inv[8];
   assign rsp.singular = flags.singular;
   assign rsp.saturated = flags.saturated;
endmodule
